/* rtl/core/cio_pkg.sv */
`timescale 1ns / 1ps

package cio_pkg;

  // Operation codes; code 3 is treated as multiply (bit 1 selects the multiplier)
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam int OP_MUL_BIT = 1;

  localparam int OPND_W  = 64;
  localparam int WIDE_W  = 2 * OPND_W;
  localparam int HALF_W  = OPND_W / 2;
  localparam int BITS_W  = 7;   // holds a bit count up to 64

  // Stage 1 contents: extended operands and result type
  typedef struct packed {
    logic [1:0]        op;
    logic [OPND_W-1:0] a_lo;
    logic              a_neg;
    logic [OPND_W-1:0] b_lo;
    logic              b_neg;
    logic              res_signed;
    logic [BITS_W-1:0] res_w;
  } cio_s1_t;

  // Exact 128-bit result plus result type
  typedef struct packed {
    logic [WIDE_W-1:0] r;
    logic              res_signed;
    logic [BITS_W-1:0] res_w;
  } cio_res_t;

  // Load enables for the pipeline registers
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } cio_stage_en_t;

  // Bit width of a width code, clamped to the configured maximum
  function automatic logic [BITS_W-1:0] cio_width(input logic [1:0] code,
                                                  input logic [BITS_W-1:0] maxw);
    logic [BITS_W-1:0] w;
    w = 7'd8 << code;
    return (w > maxw) ? maxw : w;
  endfunction

  // Mask of the low w bits
  function automatic logic [OPND_W-1:0] cio_mask(input logic [BITS_W-1:0] w);
    logic [OPND_W-1:0] one;
    one = {{(OPND_W-1){1'b0}}, 1'b1};
    return (w >= 7'(OPND_W)) ? {OPND_W{1'b1}} : ((one << w) - one);
  endfunction

  // Low 64 bits of an operand after sign or zero extension
  function automatic logic [OPND_W-1:0] cio_extend(input logic [OPND_W-1:0] raw,
                                                   input logic sgn,
                                                   input logic [BITS_W-1:0] w);
    logic [OPND_W-1:0] m;
    logic [OPND_W-1:0] v;
    logic [BITS_W-1:0] top;
    m   = cio_mask(w);
    v   = raw & m;
    top = w - 7'd1;
    if (sgn && v[top[5:0]]) begin
      v = v | ~m;
    end
    return v;
  endfunction

endpackage

/* rtl/core/cio_front.sv */
`timescale 1ns / 1ps

module cio_front #(
  parameter int MAX_OPERAND_BITS = 64
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [1:0]                operation,
  input  logic [cio_pkg::OPND_W-1:0] operand_a,
  input  logic                      a_is_signed,
  input  logic [1:0]                a_width_code,
  input  logic [cio_pkg::OPND_W-1:0] operand_b,
  input  logic                      b_is_signed,
  input  logic [1:0]                b_width_code,
  input  logic                      res_is_signed,
  input  logic [1:0]                res_width_code,
  output cio_pkg::cio_s1_t          s1
);
  import cio_pkg::*;

  localparam logic [BITS_W-1:0] MAX_W = BITS_W'(MAX_OPERAND_BITS);

  logic [OPND_W-1:0] a_ext;
  logic [OPND_W-1:0] b_ext;

  // Operand extension to the low word; the high word is all sign
  assign a_ext = cio_extend(operand_a, a_is_signed, cio_width(a_width_code, MAX_W));
  assign b_ext = cio_extend(operand_b, b_is_signed, cio_width(b_width_code, MAX_W));

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (en) begin
      s1.op         <= operation;
      s1.a_lo       <= a_ext;
      s1.a_neg      <= a_is_signed & a_ext[OPND_W-1];
      s1.b_lo       <= b_ext;
      s1.b_neg      <= b_is_signed & b_ext[OPND_W-1];
      s1.res_signed <= res_is_signed;
      s1.res_w      <= cio_width(res_width_code, MAX_W);
    end
  end

endmodule

/* rtl/core/cio_arith.sv */
`timescale 1ns / 1ps

module cio_arith (
  input  logic                  clk,
  input  cio_pkg::cio_stage_en_t en,
  input  cio_pkg::cio_s1_t      s1,
  output cio_pkg::cio_res_t     s3
);
  import cio_pkg::*;

  logic                  is_mul;
  logic [OPND_W-1:0]     p00;
  logic [OPND_W-1:0]     p01;
  logic [OPND_W-1:0]     p10;
  logic [OPND_W-1:0]     p11;
  logic [OPND_W-1:0]     corr;
  logic [WIDE_W-1:0]     sum;
  logic                  res_signed;
  logic [BITS_W-1:0]     res_w;

  logic [WIDE_W-1:0]     a_wide;
  logic [WIDE_W-1:0]     b_wide;
  logic [WIDE_W-1:0]     b_opnd;
  logic                  sub;
  logic [OPND_W-1:0]     corr_a;
  logic [OPND_W-1:0]     corr_b;
  logic [OPND_W:0]       mid;
  logic [WIDE_W-1:0]     prod;

  assign a_wide = {{OPND_W{s1.a_neg}}, s1.a_lo};
  assign b_wide = {{OPND_W{s1.b_neg}}, s1.b_lo};
  assign sub    = (s1.op == OP_SUB);
  assign b_opnd = sub ? ~b_wide : b_wide;

  // Upper halves are all ones for a negative operand: their cross terms reduce to negation
  assign corr_a = s1.a_neg ? (~s1.b_lo + 64'd1) : '0;
  assign corr_b = s1.b_neg ? (~s1.a_lo + 64'd1) : '0;

  // Stage 2: add/subtract, or 32x32 partial products
  always_ff @(posedge clk) begin
    if (en.s2) begin
      is_mul     <= s1.op[OP_MUL_BIT];
      p00        <= s1.a_lo[HALF_W-1:0]      * s1.b_lo[HALF_W-1:0];
      p01        <= s1.a_lo[HALF_W-1:0]      * s1.b_lo[OPND_W-1:HALF_W];
      p10        <= s1.a_lo[OPND_W-1:HALF_W] * s1.b_lo[HALF_W-1:0];
      p11        <= s1.a_lo[OPND_W-1:HALF_W] * s1.b_lo[OPND_W-1:HALF_W];
      corr       <= corr_a + corr_b;
      sum        <= a_wide + b_opnd + {{(WIDE_W-1){1'b0}}, sub};
      res_signed <= s1.res_signed;
      res_w      <= s1.res_w;
    end
  end

  // Partial product combine
  assign mid  = {1'b0, p01} + {1'b0, p10};
  assign prod = {p11, p00}
              + ({{(WIDE_W-OPND_W-1){1'b0}}, mid} << HALF_W)
              + {corr, {OPND_W{1'b0}}};

  // Stage 3 register
  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3.r          <= is_mul ? prod : sum;
      s3.res_signed <= res_signed;
      s3.res_w      <= res_w;
    end
  end

endmodule

/* rtl/core/cio_check.sv */
`timescale 1ns / 1ps

module cio_check (
  input  logic                       clk,
  input  logic                       en,
  input  cio_pkg::cio_res_t          s3,
  output logic [cio_pkg::OPND_W-1:0] result_value,
  output logic                       overflowed
);
  import cio_pkg::*;

  logic [OPND_W-1:0] m;
  logic [OPND_W-1:0] sign_span;
  logic [OPND_W-1:0] lo;
  logic [OPND_W-1:0] hi;
  logic [OPND_W-1:0] upper;
  logic              fit_u;
  logic              fit_s;

  assign m         = cio_mask(s3.res_w);
  assign lo        = s3.r[OPND_W-1:0];
  assign hi        = s3.r[WIDE_W-1:OPND_W];
  // Bits from the result sign bit up must all match for a signed fit
  assign sign_span = ~(m >> 1);
  assign upper     = lo & sign_span;
  assign fit_u     = (hi == '0) && ((lo & ~m) == '0);
  assign fit_s     = (hi == {OPND_W{lo[OPND_W-1]}})
                  && ((upper == '0) || (upper == sign_span));

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      result_value <= lo & m;
      overflowed   <= s3.res_signed ? ~fit_s : ~fit_u;
    end
  end

endmodule

/* rtl/core/checked_integer_arith_overflow_top.sv */
`timescale 1ns / 1ps
// Throughput: one request per cycle while m_axis_tready does not stall the pipeline;
// four registers (operands, partial products, 128-bit sum, checked result) lie between
// s_axis and m_axis, and the 32x32 partial products set the clock.
// Backpressure stalls only the stages that hold data; empty stages keep filling.
// Reset (rst, synchronous, active high) clears all stage valid bits; no other state.

module checked_integer_arith_overflow_top #(
  parameter int MAX_OPERAND_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operand_a[63:0], a_is_signed[64], a_width_code[66:65], operand_b[130:67],
  // b_is_signed[131], b_width_code[133:132], res_is_signed[134], res_width_code[136:135]
  input  logic [143:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_value[63:0]
  output logic [63:0]  m_axis_tdata,
  // overflowed[0]
  output logic [0:0]   m_axis_tuser
);
  import cio_pkg::*;

  logic          v1;
  logic          v2;
  logic          v3;
  logic          v4;
  cio_stage_en_t en;
  cio_s1_t       s1;
  cio_res_t      s3;
  logic          ovf;

  // Stage advance: a stage loads when it is empty or its contents move on
  assign en.s4 = ~v4 | m_axis_tready;
  assign en.s3 = ~v3 | en.s4;
  assign en.s2 = ~v2 | en.s3;
  assign en.s1 = ~v1 | en.s2;

  assign s_axis_tready = en.s1;
  assign m_axis_tvalid = v4;
  assign m_axis_tuser  = ovf;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.s1) v1 <= s_axis_tvalid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en.s4) v4 <= v3;
    end
  end

  cio_front #(
    .MAX_OPERAND_BITS(MAX_OPERAND_BITS)
  ) u_front (
    .clk            (clk),
    .en             (en.s1),
    .operation      (s_axis_tuser),
    .operand_a      (s_axis_tdata[63:0]),
    .a_is_signed    (s_axis_tdata[64]),
    .a_width_code   (s_axis_tdata[66:65]),
    .operand_b      (s_axis_tdata[130:67]),
    .b_is_signed    (s_axis_tdata[131]),
    .b_width_code   (s_axis_tdata[133:132]),
    .res_is_signed  (s_axis_tdata[134]),
    .res_width_code (s_axis_tdata[136:135]),
    .s1             (s1)
  );

  cio_arith u_arith (
    .clk (clk),
    .en  (en),
    .s1  (s1),
    .s3  (s3)
  );

  cio_check u_check (
    .clk          (clk),
    .en           (en.s4),
    .s3           (s3),
    .result_value (m_axis_tdata),
    .overflowed   (ovf)
  );

  // Full pipeline with a stalled output must refuse new requests
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && !m_axis_tready) |-> !s_axis_tready)
    else $error("request accepted while pipeline full and stalled");

  // An accepted request occupies the first stage
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> v1)
    else $error("accepted request lost at stage 1");

  // Data leaving stage 3 shows up at the output
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (v3 && (!v4 || m_axis_tready)) |=> m_axis_tvalid)
    else $error("stage 3 result did not reach output");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule
